/* rtl/core/lttb_pkg.sv */
// shared types and constants of the lttb downsampler
// used by lttb_div, lttb_oq and lttb_downsampler_core, no dependencies
package lttb_pkg;

	localparam int MAX_SAMPLES = 2048;
	localparam int SAMPLE_BITS = 16;
	localparam int IDX_W = $clog2(MAX_SAMPLES);
	localparam int CNT_W = IDX_W + 1;
	localparam int BND_W = IDX_W + 3;
	localparam int ISUM_W = IDX_W + CNT_W;
	localparam int VSUM_W = SAMPLE_BITS + CNT_W;
	localparam int AREA_W = 2 * IDX_W + SAMPLE_BITS + 4;

	localparam logic [7:0] CFG_SAMPLE_COUNT = 8'd0;
	localparam logic [7:0] CFG_TARGET_POINTS = 8'd1;

	localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = CNT_W'(MAX_SAMPLES);
	localparam logic [CNT_W-1:0] TARGET_POINTS_RST = CNT_W'(256);

	// one kept item on its way out
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [SAMPLE_BITS-1:0] val;
		logic done;
	} res_t;

	// divider result bundle
	typedef struct packed {
		logic done;
		logic [IDX_W-1:0] quo;
		logic [IDX_W-1:0] rem;
	} div_res_t;

endpackage

/* rtl/core/lttb_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module lttb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/lttb_div.sv */
// restoring divider, one quotient bit per cycle, for the bucket step
// depends on lttb_pkg
module lttb_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lttb_pkg::IDX_W-1:0] num,
	input  logic [lttb_pkg::IDX_W-1:0] den,
	output lttb_pkg::div_res_t         res
);

	localparam int W = lttb_pkg::IDX_W;

	logic busy_q;
	logic done_q;
	logic [$clog2(W+1)-1:0] cnt_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] den_q;
	logic [W:0] rem_sh;
	logic ge;

	// trial subtract of one bit
	assign rem_sh = {rem_q, quo_q[W-1]};
	assign ge = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= ($clog2(W+1))'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ($clog2(W+1))'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? W'(rem_sh - {1'b0, den_q}) : W'(rem_sh);
		end
	end

	assign res.done = done_q;
	assign res.quo = quo_q;
	assign res.rem = rem_q;

endmodule

/* rtl/core/lttb_oq.sv */
// four entry output queue, takes up to two items per cycle
// depends on lttb_pkg
module lttb_oq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_a,
	input  lttb_pkg::res_t     res_a,
	input  logic               push_b,
	input  lttb_pkg::res_t     res_b,
	output logic               room,
	output logic [2:0]         count,
	output logic               out_valid,
	input  logic               out_ready,
	output lttb_pkg::res_t     head
);

	lttb_pkg::res_t ent_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;
	logic pop;

	assign pop = out_valid && out_ready;
	assign out_valid = cnt_q != 3'd0;
	assign head = ent_q[rp_q];
	assign room = cnt_q <= 3'd2;
	assign count = cnt_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + 2'(push_a) + 2'(push_b);
			rp_q <= rp_q + 2'(pop);
			cnt_q <= cnt_q + 3'(push_a) + 3'(push_b) - 3'(pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push_a) begin
			ent_q[wp_q] <= res_a;
		end
		if (push_b) begin
			ent_q[wp_q + 2'd1] <= res_b;
		end
	end

endmodule

/* rtl/core/lttb_downsampler_core.sv */
// lttb downsampler top level: sample store ram, bucket bounds, area scan
// an item that closes a bucket yields its result after the scan of that bucket ends,
// other kept items are written to the output queue when they are accepted
// the sample store has one read port, which rescans each bucket once;
// items are not taken during a scan
// reset and every write to the sample count or target points register hold items off while the bound division runs
module lttb_downsampler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [15:0] sample_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] kept_index,
	output logic signed [15:0] kept_value,
	output logic        record_done
);

	localparam int IW = lttb_pkg::IDX_W;
	localparam int CW = lttb_pkg::CNT_W;
	localparam int BW = lttb_pkg::BND_W;
	localparam int SW = lttb_pkg::SAMPLE_BITS;
	localparam int ISW = lttb_pkg::ISUM_W;
	localparam int VSW = lttb_pkg::VSUM_W;
	localparam int AW = lttb_pkg::AREA_W;
	localparam int DXW = ISW + 1;
	localparam int DYW = VSW + 1;
	localparam int MW = AW - 1;

	typedef enum logic [6:0] {
		S_DIV  = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_RDP  = 7'b0000100,
		S_YP   = 7'b0001000,
		S_DXY  = 7'b0010000,
		S_SCAN = 7'b0100000,
		S_PUSH = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration and bound constants
	logic [CW-1:0] sc_q, tp_q;
	logic div_start_q;
	logic [IW-1:0] qs_q, rs_q;
	lttb_pkg::div_res_t div_res;

	// record state
	logic [IW-1:0] arr_q, bucket_q, prev_q;
	logic [ISW-1:0] asum_q;
	logic signed [VSW-1:0] vsum_q;
	logic [CW-1:0] acnt_q;
	logic [BW-1:0] cs_q, lo_q, hq_q;
	logic [IW-1:0] hr_q;

	// scan state
	logic [CW-1:0] c_q;
	logic [IW-1:0] p_q, j_q, st_q, end_q;
	logic [ISW-1:0] isum_q;
	logic signed [VSW-1:0] vs_q;
	logic signed [SW-1:0] yp_q;
	logic [ISW-1:0] cp_q;
	logic signed [VSW-1:0] cyp_q;
	logic signed [DXW-1:0] dx_q;
	logic signed [DYW-1:0] dy_q;
	logic pend_q;
	logic [IW-1:0] last_idx_q;
	logic [SW-1:0] last_val_q;
	logic rv_s1, v_s2, v_s3;
	logic [IW-1:0] j_s1, j_s2, j_s3;
	logic signed [MW-1:0] m1_s2, m2_s2;
	logic [SW-1:0] y_s2, y_s3;
	logic [AW-1:0] area_s3;
	logic have_q;
	logic [AW-1:0] best_q;
	logic [IW-1:0] bpos_q;
	logic [SW-1:0] bval_q;

	// ram ports
	logic re;
	logic [IW-1:0] raddr;
	logic [SW-1:0] rdata;

	// queue ports
	logic push_a, push_b, oq_room;
	logic [2:0] oq_cnt;
	lttb_pkg::res_t res_a, res_b, head;

	// combinational helpers
	logic [CW-1:0] n_len;
	logic [IW-1:0] dv;
	logic keep_all, few, acc, cfg_acc, cfg_hit;
	logic [IW-1:0] i_idx;
	logic last;
	logic bucket_open, in_next, trig;
	logic [BW-1:0] hi_b, hi_clip;
	logic [ISW-1:0] asum_n;
	logic signed [VSW-1:0] vsum_n;
	logic [CW-1:0] acnt_n;
	logic [BW-1:0] rs_lo, rs_hq, adv_hq;
	logic [IW-1:0] rs_hr, adv_hr;
	logic [IW-1:0] src_q, src_r;
	logic iss, scan_end;
	logic signed [AW-1:0] adiff;

	// one step of k*(n-2) = q*(t-2) + r
	function automatic logic [BW+IW-1:0] bnd_step(input logic [BW-1:0] q,
			input logic [IW-1:0] r, input logic [IW-1:0] qs, input logic [IW-1:0] rs,
			input logic [IW-1:0] d);
		logic [IW:0] r2;
		logic [BW-1:0] qn;
		logic [IW-1:0] rn;
		r2 = {1'b0, r} + {1'b0, rs};
		if (r2 >= {1'b0, d}) begin
			rn = IW'(r2 - {1'b0, d});
			qn = q + BW'(qs) + BW'(1);
		end else begin
			rn = IW'(r2);
			qn = q + BW'(qs);
		end
		return {qn, rn};
	endfunction

	// record length and mode
	always_comb begin
		if (sc_q == '0) begin
			n_len = CW'(1);
		end else if (sc_q > CW'(lttb_pkg::MAX_SAMPLES)) begin
			n_len = CW'(lttb_pkg::MAX_SAMPLES);
		end else begin
			n_len = sc_q;
		end
	end
	assign dv = IW'(tp_q - CW'(2));
	assign keep_all = tp_q >= n_len;
	assign few = tp_q < CW'(3);

	assign cfg_ready = 1'b1;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign cfg_hit = cfg_index == lttb_pkg::CFG_SAMPLE_COUNT
		|| cfg_index == lttb_pkg::CFG_TARGET_POINTS;
	assign in_ready = (state_q == S_IDLE) && oq_room;
	assign acc = in_valid && in_ready;

	assign i_idx = (CW'(arr_q) >= n_len) ? IW'(n_len - CW'(1)) : arr_q;
	assign last = CW'(i_idx) == n_len - CW'(1);

	// bucket bookkeeping for the arriving item
	assign bucket_open = CW'(bucket_q) < tp_q - CW'(2);
	assign hi_b = hq_q + BW'(1);
	assign hi_clip = (hi_b > BW'(n_len)) ? BW'(n_len) : hi_b;
	assign in_next = BW'(i_idx) >= lo_q;
	assign trig = !keep_all && !few && (i_idx != '0) && bucket_open
		&& (BW'(i_idx) == hi_clip - BW'(1));
	assign asum_n = asum_q + (in_next ? ISW'(i_idx) : ISW'(0));
	assign vsum_n = vsum_q + (in_next ? VSW'(sample_value) : VSW'(0));
	assign acnt_n = acnt_q + CW'(in_next);

	// bound restart and advance
	assign src_q = (state_q == S_DIV) ? div_res.quo : qs_q;
	assign src_r = (state_q == S_DIV) ? div_res.rem : rs_q;
	assign rs_lo = BW'(src_q) + BW'(1);
	assign {rs_hq, rs_hr} = bnd_step(BW'(src_q), src_r, src_q, src_r, dv);
	assign {adv_hq, adv_hr} = bnd_step(hq_q, hr_q, qs_q, rs_q, dv);

	// results pushed on acceptance or at the end of a scan
	always_comb begin
		push_a = 1'b0;
		push_b = 1'b0;
		res_a = '{idx: i_idx, val: sample_value, done: last};
		res_b = '{idx: i_idx, val: sample_value, done: 1'b1};
		if (state_q == S_PUSH) begin
			push_a = 1'b1;
			res_a = '{idx: bpos_q, val: bval_q, done: 1'b0};
			push_b = pend_q;
			res_b = '{idx: last_idx_q, val: last_val_q, done: 1'b1};
		end else if (acc) begin
			if (keep_all) begin
				push_a = 1'b1;
			end else if (few) begin
				if (i_idx == '0) begin
					push_a = 1'b1;
					res_a.done = 1'b0;
					push_b = last;
				end else begin
					push_a = last;
				end
			end else if (i_idx == '0) begin
				push_a = 1'b1;
				res_a.done = 1'b0;
			end else begin
				push_a = last && !trig;
			end
		end
	end

	// scan read issue
	assign iss = (state_q == S_SCAN) && (j_q < end_q);
	assign scan_end = (state_q == S_SCAN) && !iss && !rv_s1 && !v_s2 && !v_s3;
	assign re = (state_q == S_RDP) || iss;
	assign raddr = (state_q == S_RDP) ? p_q : j_q;

	// signed area before taking the magnitude
	assign adiff = AW'(m1_s2) - AW'(m2_s2);

	// control and record state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_DIV;
			sc_q <= lttb_pkg::SAMPLE_COUNT_RST;
			tp_q <= lttb_pkg::TARGET_POINTS_RST;
			div_start_q <= 1'b1;
			arr_q <= '0;
			bucket_q <= '0;
			prev_q <= '0;
			asum_q <= '0;
			vsum_q <= '0;
			acnt_q <= '0;
			pend_q <= 1'b0;
			rv_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			have_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			rv_s1 <= iss;
			v_s2 <= rv_s1;
			v_s3 <= v_s2;
			if (cfg_acc && cfg_hit) begin
				if (cfg_index == lttb_pkg::CFG_SAMPLE_COUNT) begin
					sc_q <= cfg_data;
				end else begin
					tp_q <= cfg_data;
				end
				div_start_q <= 1'b1;
				state_q <= S_DIV;
				arr_q <= '0;
				bucket_q <= '0;
				prev_q <= '0;
				asum_q <= '0;
				vsum_q <= '0;
				acnt_q <= '0;
				pend_q <= 1'b0;
			end else begin
				case (state_q)
					S_DIV: begin
						if (div_res.done && !div_start_q) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (acc) begin
							if (last) begin
								arr_q <= '0;
								bucket_q <= '0;
								prev_q <= '0;
								asum_q <= '0;
								vsum_q <= '0;
								acnt_q <= '0;
							end else begin
								arr_q <= i_idx + IW'(1);
								if (trig) begin
									bucket_q <= bucket_q + IW'(1);
									asum_q <= '0;
									vsum_q <= '0;
									acnt_q <= '0;
								end else if (!keep_all && !few && i_idx != '0
										&& bucket_open) begin
									asum_q <= asum_n;
									vsum_q <= vsum_n;
									acnt_q <= acnt_n;
								end
							end
							if (trig) begin
								pend_q <= last;
								state_q <= S_RDP;
							end
						end
					end
					S_RDP: state_q <= S_YP;
					S_YP: state_q <= S_DXY;
					S_DXY: begin
						have_q <= 1'b0;
						state_q <= S_SCAN;
					end
					S_SCAN: begin
						if (v_s3 && (!have_q || area_s3 > best_q)) begin
							have_q <= 1'b1;
						end
						if (scan_end) begin
							state_q <= S_PUSH;
						end
					end
					S_PUSH: begin
						if (!pend_q) begin
							prev_q <= bpos_q;
						end
						pend_q <= 1'b0;
						state_q <= S_IDLE;
					end
					default: state_q <= S_DIV;
				endcase
			end
		end
	end

	// bounds and scan datapath
	always_ff @(posedge clk) begin
		if ((state_q == S_DIV && div_res.done) || (acc && last)) begin
			cs_q <= BW'(1);
			lo_q <= rs_lo;
			hq_q <= rs_hq;
			hr_q <= rs_hr;
		end else if (acc && trig) begin
			cs_q <= lo_q;
			lo_q <= hi_b;
			hq_q <= adv_hq;
			hr_q <= adv_hr;
		end
		if (state_q == S_DIV && div_res.done) begin
			qs_q <= div_res.quo;
			rs_q <= div_res.rem;
		end
		// latch the bucket to decide
		if (acc && trig) begin
			c_q <= acnt_n;
			p_q <= prev_q;
			isum_q <= asum_n;
			vs_q <= vsum_n;
			j_q <= IW'(cs_q);
			st_q <= IW'(cs_q);
			end_q <= (lo_q > BW'(n_len - CW'(1))) ? IW'(n_len - CW'(1)) : IW'(lo_q);
			last_idx_q <= i_idx;
			last_val_q <= sample_value;
		end
		if (state_q == S_YP) begin
			yp_q <= rdata;
			cp_q <= ISW'(c_q) * ISW'(p_q);
			cyp_q <= VSW'($signed({1'b0, c_q}) * $signed(rdata));
		end
		if (state_q == S_DXY) begin
			dx_q <= $signed({1'b0, cp_q}) - $signed({1'b0, isum_q});
			dy_q <= DYW'(vs_q) - DYW'(cyp_q);
		end
		if (iss) begin
			j_q <= j_q + IW'(1);
		end
		j_s1 <= j_q;
		// products
		m1_s2 <= MW'(dx_q) * MW'($signed(rdata) - $signed(yp_q) + 17'sd0);
		m2_s2 <= MW'($signed({1'b0, p_q}) - $signed({1'b0, j_s1})) * MW'(dy_q);
		j_s2 <= j_s1;
		y_s2 <= rdata;
		// absolute area
		area_s3 <= adiff[AW-1] ? AW'(-adiff) : AW'(adiff);
		j_s3 <= j_s2;
		y_s3 <= y_s2;
		// keep the earliest largest
		if (state_q == S_SCAN && v_s3 && (!have_q || area_s3 > best_q)) begin
			best_q <= area_s3;
			bpos_q <= j_s3;
			bval_q <= y_s3;
		end
	end

	lttb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (IW'(n_len - CW'(2))),
		.den    (dv),
		.res    (div_res)
	);

	lttb_ram #(
		.WIDTH (SW),
		.DEPTH (lttb_pkg::MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (acc),
		.waddr (i_idx),
		.wdata (sample_value),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	lttb_oq u_oq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_a    (push_a),
		.res_a     (res_a),
		.push_b    (push_b),
		.res_b     (res_b),
		.room      (oq_room),
		.count     (oq_cnt),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kept_index = head.idx;
	assign kept_value = head.val;
	assign record_done = head.done;

	// chosen sample lies inside the scanned bucket
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PUSH |-> (bpos_q >= st_q && bpos_q < end_q))
		else $error("chosen sample outside bucket");

	// the queue has room for both results of a scan
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PUSH |-> oq_cnt <= 3'd2)
		else $error("output queue overrun at scan end");

	// a write to the sample count or target points register holds off items until bounds are recomputed
	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_acc && cfg_hit) |=> !in_ready)
		else $error("item taken during bound division");

endmodule

/* tb/lttb_checker.sv */
// checker for the lttb downsampler: predicts kept items from observed
// config writes and input items, compares them against the output channel
// depends on lttb_pkg for the register index codes and the sample store depth
`timescale 1ns / 100ps

module lttb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic signed [15:0] sample_value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [10:0] kept_index,
	input  logic signed [15:0] kept_value,
	input  logic        record_done,
	output int          pending,
	output int          errors
);

	typedef struct {
		logic [10:0] idx;
		logic signed [15:0] val;
		logic done;
	} kept_item_t;

	kept_item_t kept_queue[$];

	// predictor copy of the block state
	logic signed [15:0] samples [lttb_pkg::MAX_SAMPLES];
	logic [11:0] count_reg;
	logic [11:0] target_reg;
	int arrival;
	int bucket;
	int prev_pick;
	longint idx_sum;
	longint val_sum;
	int ahead_n;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	function automatic int bucket_edge(input int k, input int n, input int t);
		return int'((longint'(k) * longint'(n - 2)) / longint'(t - 2)) + 1;
	endfunction

	task automatic clear_record();
		arrival = 0;
		bucket = 0;
		prev_pick = 0;
		idx_sum = 0;
		val_sum = 0;
		ahead_n = 0;
	endtask

	task automatic push_kept(input int idx, input logic signed [15:0] val, input logic done);
		kept_item_t k;
		k.idx = idx[10:0];
		k.val = val;
		k.done = done;
		kept_queue = {kept_queue, k};
	endtask

	// pick the sample of the current bucket with the largest triangle
	function automatic int pick_in_bucket(input int n, input int t);
		int s0, s1, best, j;
		longint yp, c, dx, dy, a, best_a;
		bit have;
		s0 = bucket_edge(bucket, n, t);
		s1 = bucket_edge(bucket + 1, n, t);
		if (s1 > n - 1) s1 = n - 1;
		yp = samples[prev_pick];
		c = ahead_n;
		dx = c * prev_pick - idx_sum;
		dy = val_sum - c * yp;
		best = s0;
		best_a = 0;
		have = 0;
		for (j = s0; j < s1; j++) begin
			a = dx * (longint'(samples[j]) - yp) - (longint'(prev_pick) - j) * dy;
			if (a < 0) a = -a;
			if (!have || a > best_a) begin
				have = 1;
				best_a = a;
				best = j;
			end
		end
		return best;
	endfunction

	task automatic take_sample(input logic signed [15:0] v);
		int n, t, i, lo, hi, pick;
		bit last;
		n = count_reg;
		if (n == 0) n = 1;
		if (n > lttb_pkg::MAX_SAMPLES) n = lttb_pkg::MAX_SAMPLES;
		t = target_reg;
		i = arrival;
		if (i >= n) i = n - 1;
		samples[i] = v;
		last = (i == n - 1);
		if (t >= n) begin
			push_kept(i, v, last);
		end else if (t < 3) begin
			if (i == 0) push_kept(0, v, 1'b0);
			if (last) push_kept(i, v, 1'b1);
		end else begin
			if (i == 0) begin
				push_kept(0, v, 1'b0);
			end else if (bucket < t - 2) begin
				lo = bucket_edge(bucket + 1, n, t);
				hi = bucket_edge(bucket + 2, n, t);
				if (hi > n) hi = n;
				if (i >= lo) begin
					idx_sum += i;
					val_sum += v;
					ahead_n++;
				end
				if (i == hi - 1) begin
					pick = pick_in_bucket(n, t);
					push_kept(pick, samples[pick], 1'b0);
					prev_pick = pick;
					bucket++;
					idx_sum = 0;
					val_sum = 0;
					ahead_n = 0;
				end
			end
			if (last) push_kept(i, v, 1'b1);
		end
		if (last) clear_record();
		else arrival = i + 1;
	endtask

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		kept_item_t k;
		if (!arst_n) begin
			count_reg = 12'(lttb_pkg::MAX_SAMPLES);
			target_reg = 12'd256;
			clear_record();
			kept_queue.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == lttb_pkg::CFG_SAMPLE_COUNT) begin
					count_reg = cfg_data;
					clear_record();
				end else if (cfg_index == lttb_pkg::CFG_TARGET_POINTS) begin
					target_reg = cfg_data;
					clear_record();
				end
			end
			if (out_valid && out_ready) begin
				if (kept_queue.size() == 0) begin
					report("unexpected item, index", kept_index, -1);
				end else begin
					k = kept_queue.pop_front();
					if (kept_index !== k.idx) report("kept_index", kept_index, k.idx);
					if (kept_value !== k.val) report("kept_value", kept_value, k.val);
					if (record_done !== k.done) report("record_done", record_done, k.done);
				end
			end
			if (in_valid && in_ready) take_sample(sample_value);
		end
		pending = kept_queue.size();
	end

endmodule

/* tb/tb.sv */
// top of the lttb downsampler testbench: clock, reset, stimulus and verdict
// depends on lttb_pkg, lttb_downsampler_core and lttb_checker
`timescale 1ns / 100ps

module tb;

	localparam logic [7:0] CFG_UNUSED = 8'd2;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] cfg_index;
	logic [11:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] sample_value;
	logic out_valid;
	logic out_ready;
	logic [10:0] kept_index;
	logic signed [15:0] kept_value;
	logic record_done;
	int pending;
	int errors;

	int send_idle;
	int recv_idle;
	int items_sent;
	int cfg_writes;
	int records_sent;

	lttb_downsampler_core uut (.*);

	lttb_checker chk (.*);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// run limit
	initial begin
		#8_000_000;
		$display("tb NOT OK");
		$finish;
	end

	task automatic send_sample(input logic signed [15:0] v);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_value <= v;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// wait until the block has drained before touching registers
	task automatic write_reg(input logic [7:0] idx, input logic [11:0] data);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	task automatic set_shape(input int n, input int t);
		write_reg(lttb_pkg::CFG_SAMPLE_COUNT, 12'(n));
		write_reg(lttb_pkg::CFG_TARGET_POINTS, 12'(t));
	endtask

	function automatic logic signed [15:0] pick_value(input int style, input int pos);
		logic signed [15:0] v;
		case (style)
			0: v = 16'($urandom);
			1: v = 16'($signed($urandom_range(0, 4)) - 2);
			2: begin
				case ($urandom_range(0, 3))
					0: v = -16'sd32768;
					1: v = 16'sd32767;
					2: v = 16'sd0;
					default: v = -16'sd1;
				endcase
			end
			default: v = 16'(pos * 97);
		endcase
		return v;
	endfunction

	// one record, or a cut-off one when len is short
	task automatic send_record(input int len);
		int style, p;
		style = $urandom_range(0, 3);
		for (p = 0; p < len; p++) send_sample(pick_value(style, p));
		records_sent++;
	endtask

	initial begin
		int mode, goal, n, t, r, nrec, k, len;
		cfg_valid <= 1'b0;
		cfg_index <= lttb_pkg::CFG_SAMPLE_COUNT;
		cfg_data <= '0;
		in_valid <= 1'b0;
		sample_value <= '0;
		send_idle = 0;
		recv_idle = 0;
		items_sent = 0;
		cfg_writes = 0;
		records_sent = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single sample record, emitted twice
		set_shape(1, 0);
		send_sample(-16'sd32768);
		send_sample(16'sd32767);
		// zero count is one sample, unused register index changes nothing
		set_shape(0, 5);
		write_reg(CFG_UNUSED, 12'hfff);
		send_sample(-16'sd1);
		// two targets keep only the ends
		set_shape(5, 2);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		send_sample(16'sd0);
		send_sample(16'sd0);
		send_sample(-16'sd1);
		// keep all
		set_shape(3, 3);
		send_sample(16'sd1);
		send_sample(-16'sd32768);
		send_sample(16'sd32767);
		// real buckets, with two equal samples in the first bucket
		set_shape(8, 4);
		send_sample(16'sd0);
		send_sample(16'sd5);
		send_sample(16'sd5);
		send_sample(-16'sd32768);
		send_sample(16'sd32767);
		send_sample(16'sd0);
		send_sample(16'sd0);
		send_sample(16'sd3);
		// write in the middle of a record restarts it
		set_shape(6, 3);
		send_sample(16'sd7);
		send_sample(16'sd9);
		set_shape(6, 3);
		send_record(6);

		// random phases with different idling
		for (mode = 0; mode < 3; mode++) begin
			send_idle = (mode == 0) ? 26 : (mode == 1) ? 85 : 0;
			recv_idle = (mode == 0) ? 85 : (mode == 1) ? 26 : 0;
			goal = items_sent + 590;
			while (items_sent < goal) begin
				r = $urandom_range(0, 19);
				if (r == 0) n = $urandom_range(200, 600);
				else if (r == 1) n = 0;
				else n = $urandom_range(1, 40);
				r = $urandom_range(0, 9);
				if (r == 0) t = $urandom_range(0, 2);
				else if (r == 1) t = n + $urandom_range(0, 5);
				else if (n > 4) t = $urandom_range(3, n - 1);
				else t = 3;
				set_shape(n, t);
				len = (n == 0) ? 1 : n;
				nrec = $urandom_range(1, 3);
				for (k = 0; k < nrec; k++) begin
					if ($urandom_range(0, 7) == 0) send_record($urandom_range(0, len - 1));
					else send_record(len);
				end
			end
			// saturating count, cut-off records of the longest length
			if (mode == 2) begin
				set_shape(4095, 2048);
				send_record(40);
				set_shape(4095, 1500);
				send_record(60);
				set_shape(lttb_pkg::MAX_SAMPLES, 4095);
				send_record(5);
			end
		end

		// drain
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d samples in %0d records over %0d register writes",
			items_sent, records_sent, cfg_writes);
		$display("idle mixes: sender-heavy, receiver-heavy, none; %0d mismatches", errors);
		if (errors == 0) $display("tb OK");
		else $display("tb NOT OK");
		$finish;
	end

endmodule

/* files.f */
rtl/core/lttb_pkg.sv
rtl/core/lttb_ram.sv
rtl/core/lttb_div.sv
rtl/core/lttb_oq.sv
rtl/core/lttb_downsampler_core.sv
tb/lttb_checker.sv
tb/tb.sv
